[rtl/camera_byte_to_rgb_hsv_pixel_assert.svh]
// Assertion macros shared by the camera pixel block.
// Needs clk and rst in the scope of each use; no other dependencies.
`ifndef CAMERA_BYTE_TO_RGB_HSV_PIXEL_ASSERT_SVH
`define CAMERA_BYTE_TO_RGB_HSV_PIXEL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CBRH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBRH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cbrh_pkg.sv]
// Shared types and constants for the camera pixel block.
// Used by the controller, datapath, divider and top level; no dependencies.
package cbrh_pkg;

  localparam int HUE_BITS_DEF = 12;
  localparam int HUE_OUT_W    = 12;
  localparam int CH_W         = 8;
  localparam int DEN_W        = 11;  // holds 6 * delta
  localparam int SAT_STEPS    = 8;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HSV_ENABLE = 1'd1;

  localparam logic [CH_W-1:0] MASK_HI5 = 8'hF8;
  localparam logic [CH_W-1:0] MASK_LO3 = 8'h07;
  localparam logic [CH_W-1:0] MASK_HI3 = 8'hE0;
  localparam logic [CH_W-1:0] MASK_LO5 = 8'h1F;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAXMIN,
    S_PREP,
    S_SAT_LD,
    S_SAT,
    S_HUE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic take;
    logic maxmin;
    logic prep;
    logic zero_hsv;
    logic div_load;
    logic div_hue;
    logic cap_sat;
    logic cap_hue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic hsv_on;
    logic delta_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[rtl/cbrh_div.sv]
// Restoring divider, one quotient bit per cycle, with round-half-up flag.
// Depends on cbrh_pkg for the divisor width.
module cbrh_div #(
  parameter int QW = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [cbrh_pkg::DEN_W-1:0]     rem_init,
  input  logic [QW-1:0]                  dividend,
  input  logic [cbrh_pkg::DEN_W-1:0]     den,
  input  logic [$clog2(QW + 1)-1:0]      steps,
  output logic                           done,
  output logic [QW-1:0]                  quot,
  output logic                           round_up
);

  localparam int CW = $clog2(QW + 1);

  logic [cbrh_pkg::DEN_W-1:0] rem;
  logic [cbrh_pkg::DEN_W-1:0] rem_next;
  logic [cbrh_pkg::DEN_W-1:0] den_r;
  logic [QW-1:0]              dvd;
  logic [CW-1:0]              count;
  logic [cbrh_pkg::DEN_W:0]   rem2;
  logic [cbrh_pkg::DEN_W:0]   rem_sub;
  logic                       fits;

  always_comb begin
    rem2     = {rem, dvd[QW-1]};
    fits     = (rem2 >= {1'b0, den_r});
    rem_sub  = rem2 - {1'b0, den_r};
    rem_next = fits ? rem_sub[cbrh_pkg::DEN_W-1:0] : rem2[cbrh_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= steps;
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= rem_init;
      dvd   <= dividend;
      quot  <= '0;
      den_r <= den;
    end else if (count != '0) begin
      rem  <= rem_next;
      dvd  <= dvd << 1;
      quot <= {quot[QW-2:0], fits};
    end
  end

  assign done     = (count == '0);
  // twice the remainder at or past the divisor: round the quotient up
  assign round_up = ({rem, 1'b0} >= {1'b0, den_r});

endmodule

[rtl/cbrh_dp.sv]
// Datapath: config registers, byte pairing, channel unpack, HSV arithmetic
// and output register. Depends on cbrh_pkg, cbrh_div and the assert header.
`include "camera_byte_to_rgb_hsv_pixel_assert.svh"

module cbrh_dp #(
  parameter int HUE_BITS = cbrh_pkg::HUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cbrh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                              cfg_data,
  input  logic [cbrh_pkg::CH_W-1:0]         raw_byte,
  input  logic                              frame_start,
  output logic [cbrh_pkg::HUE_OUT_W-1:0]    red_or_hue,
  output logic [cbrh_pkg::CH_W-1:0]         green_or_saturation,
  output logic [cbrh_pkg::CH_W-1:0]         blue_or_value,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  input  cbrh_pkg::cmd_t                    cmd,
  output cbrh_pkg::status_t                 st
);

  localparam int QW = (HUE_BITS > cbrh_pkg::SAT_STEPS) ? HUE_BITS : cbrh_pkg::SAT_STEPS;
  localparam int CW = $clog2(QW + 1);
  localparam int CH = cbrh_pkg::CH_W;
  localparam int DW = cbrh_pkg::DEN_W;
  localparam int OW = cbrh_pkg::HUE_OUT_W;

  logic          pixel_mode;
  logic          hsv_enable;
  logic          byte_pending;
  logic [CH-1:0] held_byte;
  logic [CH-1:0] red, green, blue;
  logic [CH-1:0] mx, mn, delta;
  logic [DW-1:0] num, den6;
  logic [CH-1:0] sat;
  logic [OW-1:0] hue;

  logic [CH-1:0]       delta_c;
  logic [DW-1:0]       den6_c;
  logic signed [11:0]  n_raw, n_fold;
  logic [15:0]         sat_n;
  logic [DW-1:0]       div_rem_init, div_den;
  logic [QW-1:0]       div_dividend, quot;
  logic [CW-1:0]       div_steps;
  logic                div_done, round_up;
  logic [CH:0]         sat_sum;
  logic [HUE_BITS-1:0] hue_sum;
  logic [OW-1:0]       hue_out;
  logic                out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= 1'b0;
      hsv_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbrh_pkg::REG_PIXEL_MODE: pixel_mode <= cfg_data;
        cbrh_pkg::REG_HSV_ENABLE: hsv_enable <= cfg_data;
      endcase
    end
  end

  // byte pairing
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pending <= 1'b0;
    end else if (cmd.take) begin
      if (!pixel_mode) begin
        byte_pending <= 1'b0;
      end else if (frame_start || !byte_pending) begin
        byte_pending <= 1'b1;
      end else begin
        byte_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (!pixel_mode) begin
        red   <= raw_byte;
        green <= raw_byte;
        blue  <= raw_byte;
      end else if (frame_start || !byte_pending) begin
        held_byte <= raw_byte;
      end else begin
        red   <= held_byte & cbrh_pkg::MASK_HI5;
        green <= ((held_byte & cbrh_pkg::MASK_LO3) << 5) |
                 ((raw_byte & cbrh_pkg::MASK_HI3) >> 3);
        blue  <= (raw_byte & cbrh_pkg::MASK_LO5) << 3;
      end
    end
  end

  // hue numerator by sector, red winning ties, then green
  always_comb begin
    delta_c = mx - mn;
    den6_c  = DW'({delta_c, 2'b00}) + DW'({delta_c, 1'b0});
    if (red == mx) begin
      n_raw = $signed({4'b0, green}) - $signed({4'b0, blue});
    end else if (green == mx) begin
      n_raw = $signed({4'b0, blue}) - $signed({4'b0, red}) +
              $signed({3'b0, delta_c, 1'b0});
    end else begin
      n_raw = $signed({4'b0, red}) - $signed({4'b0, green}) +
              $signed({2'b0, delta_c, 2'b00});
    end
    n_fold = n_raw[11] ? (n_raw + $signed({1'b0, den6_c})) : n_raw;
  end

  always_ff @(posedge clk) begin
    if (cmd.maxmin) begin
      mx <= (red >= green) ? ((red >= blue) ? red : blue)
                           : ((green >= blue) ? green : blue);
      mn <= (red <= green) ? ((red <= blue) ? red : blue)
                           : ((green <= blue) ? green : blue);
    end
    if (cmd.prep) begin
      delta <= delta_c;
      den6  <= den6_c;
      num   <= n_fold[DW-1:0];
    end
  end

  // delta * 255; the top byte is already below max, so eight steps remain
  assign sat_n = {delta, 8'b0} - {8'b0, delta};

  always_comb begin
    if (cmd.div_hue) begin
      div_rem_init = num;
      div_dividend = '0;
      div_den      = den6;
      div_steps    = CW'(HUE_BITS);
    end else begin
      div_rem_init = DW'(sat_n[15:8]);
      div_dividend = QW'(sat_n[7:0]) << (QW - cbrh_pkg::SAT_STEPS);
      div_den      = DW'(mx);
      div_steps    = CW'(cbrh_pkg::SAT_STEPS);
    end
  end

  cbrh_div #(
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.div_load),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (quot),
    .round_up (round_up)
  );

  assign sat_sum = {1'b0, quot[CH-1:0]} + (CH + 1)'(round_up);
  // a rounded full turn wraps to zero
  assign hue_sum = quot[HUE_BITS-1:0] + HUE_BITS'(round_up);

  generate
    if (HUE_BITS >= OW) begin : g_hue_trim
      assign hue_out = hue_sum[OW-1:0];
    end else begin : g_hue_ext
      assign hue_out = {{(OW - HUE_BITS){1'b0}}, hue_sum};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.zero_hsv) begin
      sat <= '0;
      hue <= '0;
    end
    if (cmd.cap_sat) begin
      sat <= sat_sum[CH-1:0];
    end
    if (cmd.cap_hue) begin
      hue <= hue_out;
    end
  end

  // output register
  assign out_free = !pixel_valid || !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (cmd.out_load) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (hsv_enable) begin
        red_or_hue          <= hue;
        green_or_saturation <= sat;
        blue_or_value       <= mx;
      end else begin
        red_or_hue          <= OW'(red);
        green_or_saturation <= green;
        blue_or_value       <= blue;
      end
    end
  end

  always_comb begin
    st.emit       = !pixel_mode || (!frame_start && byte_pending);
    st.hsv_on     = hsv_enable;
    st.delta_zero = (mx == mn);
    st.div_done   = div_done;
    st.out_free   = out_free;
  end

  `CBRH_ASSERT_NOW(a_sat_nonzero_div, cmd.div_load && !cmd.div_hue, mx != '0, "saturation divide by zero")
  `CBRH_ASSERT_NOW(a_hue_num_range, cmd.div_load && cmd.div_hue, num < den6, "hue numerator not below 6*delta")
  `CBRH_ASSERT_NOW(a_sat_range, cmd.cap_sat, !sat_sum[CH], "saturation quotient overflow")

endmodule

[rtl/cbrh_ctrl.sv]
// Controller: sequences byte intake, HSV steps, divider runs and output load.
// Depends on cbrh_pkg and the assert header.
`include "camera_byte_to_rgb_hsv_pixel_assert.svh"

module cbrh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  cbrh_pkg::status_t st,
  output cbrh_pkg::cmd_t    cmd
);

  cbrh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbrh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    byte_stall = 1'b1;
    unique case (state)
      cbrh_pkg::S_IDLE: begin
        byte_stall = 1'b0;
        if (byte_valid) begin
          cmd.take = 1'b1;
          if (st.emit) begin
            state_next = st.hsv_on ? cbrh_pkg::S_MAXMIN : cbrh_pkg::S_FINISH;
          end
        end
      end
      cbrh_pkg::S_MAXMIN: begin
        cmd.maxmin = 1'b1;
        state_next = cbrh_pkg::S_PREP;
      end
      cbrh_pkg::S_PREP: begin
        cmd.prep = 1'b1;
        // grey pixel: hue and saturation are both zero
        if (st.delta_zero) begin
          cmd.zero_hsv = 1'b1;
          state_next   = cbrh_pkg::S_FINISH;
        end else begin
          state_next = cbrh_pkg::S_SAT_LD;
        end
      end
      cbrh_pkg::S_SAT_LD: begin
        cmd.div_load = 1'b1;
        state_next   = cbrh_pkg::S_SAT;
      end
      cbrh_pkg::S_SAT: begin
        if (st.div_done) begin
          cmd.cap_sat  = 1'b1;
          cmd.div_load = 1'b1;
          cmd.div_hue  = 1'b1;
          state_next   = cbrh_pkg::S_HUE;
        end
      end
      cbrh_pkg::S_HUE: begin
        if (st.div_done) begin
          cmd.cap_hue = 1'b1;
          state_next  = cbrh_pkg::S_FINISH;
        end
      end
      cbrh_pkg::S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = cbrh_pkg::S_IDLE;
        end
      end
      default: state_next = cbrh_pkg::S_IDLE;
    endcase
  end

  `CBRH_ASSERT_NEXT(a_skip_idle, cmd.take && !st.emit, state == cbrh_pkg::S_IDLE, "held byte left idle")
  `CBRH_ASSERT_NOW(a_div_nonzero, state == cbrh_pkg::S_SAT || state == cbrh_pkg::S_HUE, !st.delta_zero, "divider run on grey pixel")
  `CBRH_ASSERT_NEXT(a_hue_started, state == cbrh_pkg::S_SAT && st.div_done, !st.div_done, "hue divide not started")

endmodule

[rtl/camera_byte_to_rgb_hsv_pixel.sv]
// Top level of the camera byte to RGB/HSV pixel block.
// Depends on cbrh_pkg, cbrh_ctrl and cbrh_dp.

// Takes camera bytes one request at a time and returns one pixel per
// greyscale byte or per colour byte pair (RGB565 unpacked to 8-bit channels),
// optionally converted to HSV. One item is worked on at a time. A byte that
// only opens a pair is held and the block returns to idle; an RGB pixel
// skips the HSV steps; an HSV pixel runs through the shared bit-serial
// divider, first for saturation (8 steps) and then for hue (HUE_BITS
// steps); a grey HSV pixel skips the divider. The output register
// lets the next byte be taken while a pixel still waits downstream.
// Configuration writes are taken at any time but belong to idle periods.
module camera_byte_to_rgb_hsv_pixel #(
  parameter int HUE_BITS = cbrh_pkg::HUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cbrh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                              cfg_data,
  input  logic                              byte_valid,
  output logic                              byte_stall,
  input  logic [cbrh_pkg::CH_W-1:0]         raw_byte,
  input  logic                              frame_start,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output logic [cbrh_pkg::HUE_OUT_W-1:0]    red_or_hue,
  output logic [cbrh_pkg::CH_W-1:0]         green_or_saturation,
  output logic [cbrh_pkg::CH_W-1:0]         blue_or_value
);

  cbrh_pkg::cmd_t    cmd;
  cbrh_pkg::status_t st;

  cbrh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .st         (st),
    .cmd        (cmd)
  );

  cbrh_dp #(
    .HUE_BITS (HUE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .raw_byte            (raw_byte),
    .frame_start         (frame_start),
    .red_or_hue          (red_or_hue),
    .green_or_saturation (green_or_saturation),
    .blue_or_value       (blue_or_value),
    .pixel_valid         (pixel_valid),
    .pixel_stall         (pixel_stall),
    .cmd                 (cmd),
    .st                  (st)
  );

endmodule
